@@ hdl/matrix3x3_inverse_unit_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the 3x3 inverse unit
// Checks are clocked by clk_i and held off while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef MATRIX3X3_INVERSE_UNIT_MACROS_SVH
`define MATRIX3X3_INVERSE_UNIT_MACROS_SVH

// same-cycle implication
`define MI3_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MI3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/mi3_pkg.sv @@
// ---------------------------------------------------------------------------
// mi3_pkg
// Types, widths and index tables shared by the 3x3 inverse unit.
// ---------------------------------------------------------------------------
`default_nettype none

package mi3_pkg;

  localparam int unsigned ELEM_W   = 32;
  localparam int unsigned PROD_W   = 2 * ELEM_W;
  localparam int unsigned COF_W    = 2 * ELEM_W + 1;
  localparam int unsigned DET_W    = 3 * ELEM_W + 2;
  localparam int unsigned THR_W    = 16;
  localparam int unsigned NUM_ELEM = 9;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [COF_W-1:0]  cof_t;
  typedef logic [COF_W-1:0]         cmag_t;
  typedef logic [3:0]               idx_t;
  typedef elem_t                    mat_t [NUM_ELEM];

  typedef struct packed {
    elem_t in_r0c0;
    elem_t in_r0c1;
    elem_t in_r0c2;
    elem_t in_r1c0;
    elem_t in_r1c1;
    elem_t in_r1c2;
    elem_t in_r2c0;
    elem_t in_r2c1;
    elem_t in_r2c2;
  } in_beat_t;

  typedef struct packed {
    elem_t out_r0c0;
    elem_t out_r0c1;
    elem_t out_r0c2;
    elem_t out_r1c0;
    elem_t out_r1c1;
    elem_t out_r1c2;
    elem_t out_r2c0;
    elem_t out_r2c1;
    elem_t out_r2c2;
    logic  singular;
  } out_beat_t;

  // cofactor i = m[a]*m[b] - m[c]*m[d]
  localparam idx_t COF_IDX [NUM_ELEM][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7},
    '{4'd2, 4'd7, 4'd1, 4'd8},
    '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8},
    '{4'd0, 4'd8, 4'd2, 4'd6},
    '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6},
    '{4'd1, 4'd6, 4'd0, 4'd7},
    '{4'd0, 4'd4, 4'd1, 4'd3}
  };

  // det = m0*c0 + m1*c3 + m2*c6
  localparam idx_t DET_COF [3] = '{4'd0, 4'd3, 4'd6};

  function automatic mat_t unpack_in(input in_beat_t b);
    mat_t m;
    m[0] = b.in_r0c0;
    m[1] = b.in_r0c1;
    m[2] = b.in_r0c2;
    m[3] = b.in_r1c0;
    m[4] = b.in_r1c1;
    m[5] = b.in_r1c2;
    m[6] = b.in_r2c0;
    m[7] = b.in_r2c1;
    m[8] = b.in_r2c2;
    return m;
  endfunction

  function automatic out_beat_t pack_out(input mat_t m, input logic sing);
    out_beat_t b;
    b.out_r0c0 = m[0];
    b.out_r0c1 = m[1];
    b.out_r0c2 = m[2];
    b.out_r1c0 = m[3];
    b.out_r1c1 = m[4];
    b.out_r1c2 = m[5];
    b.out_r2c0 = m[6];
    b.out_r2c1 = m[7];
    b.out_r2c2 = m[8];
    b.singular = sing;
    return b;
  endfunction

endpackage

`default_nettype wire

@@ hdl/mi3_cofactor.sv @@
// ---------------------------------------------------------------------------
// mi3_cofactor
// Two stages: eighteen element products, then the nine cofactors.
// ---------------------------------------------------------------------------
`default_nettype none

module mi3_cofactor import mi3_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  wire logic valid_i,
  input  mat_t      mat_i,
  output logic      valid_o,
  output cof_t      cof_o [NUM_ELEM],
  output elem_t     row0_o [3]
);

  logic signed [PROD_W-1:0] prod_q [2*NUM_ELEM];
  elem_t                    row0a_q [3];
  elem_t                    row0b_q [3];
  cof_t                     cof_q [NUM_ELEM];
  logic                     v1_q, v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NUM_ELEM; i++) begin
        prod_q[2*i]   <= mat_i[COF_IDX[i][0]] * mat_i[COF_IDX[i][1]];
        prod_q[2*i+1] <= mat_i[COF_IDX[i][2]] * mat_i[COF_IDX[i][3]];
        cof_q[i]      <= COF_W'(prod_q[2*i]) - COF_W'(prod_q[2*i+1]);
      end
      for (int j = 0; j < 3; j++) begin
        row0a_q[j] <= mat_i[j];
        row0b_q[j] <= row0a_q[j];
      end
    end
  end

  assign valid_o = v2_q;
  assign cof_o   = cof_q;
  assign row0_o  = row0b_q;

endmodule

`default_nettype wire

@@ hdl/mi3_det.sv @@
// ---------------------------------------------------------------------------
// mi3_det
// Determinant by first-row expansion in split partial products, then
// magnitudes and result signs for the divider.
// ---------------------------------------------------------------------------
`default_nettype none

module mi3_det import mi3_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  cof_t                 cof_i [NUM_ELEM],
  input  elem_t                row0_i [3],
  output logic                 valid_o,
  output logic [DET_W-1:0]     ad_o,
  output cmag_t                cmag_o [NUM_ELEM],
  output logic [NUM_ELEM-1:0]  neg_o
);

  logic signed [PROD_W:0]  lo_q [3];
  logic signed [PROD_W:0]  hi_q [3];
  logic signed [DET_W-1:0] term_q [3];
  logic signed [DET_W-1:0] det_q;
  cof_t                    c3_q [NUM_ELEM];
  cof_t                    c4_q [NUM_ELEM];
  cof_t                    c5_q [NUM_ELEM];
  logic [DET_W-1:0]        ad_q;
  cmag_t                   cmag_q [NUM_ELEM];
  logic [NUM_ELEM-1:0]     neg_q;
  logic [3:0]              v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        lo_q[j]   <= row0_i[j] * $signed({1'b0, cof_i[DET_COF[j]][ELEM_W-1:0]});
        hi_q[j]   <= row0_i[j] * $signed(cof_i[DET_COF[j]][COF_W-1:ELEM_W]);
        term_q[j] <= (DET_W'(hi_q[j]) <<< ELEM_W) + DET_W'(lo_q[j]);
      end
      det_q <= term_q[0] + term_q[1] + term_q[2];
      ad_q  <= det_q[DET_W-1] ? DET_W'(-det_q) : DET_W'(det_q);
      for (int i = 0; i < NUM_ELEM; i++) begin
        c3_q[i]   <= cof_i[i];
        c4_q[i]   <= c3_q[i];
        c5_q[i]   <= c4_q[i];
        neg_q[i]  <= c5_q[i][COF_W-1] ^ det_q[DET_W-1];
        cmag_q[i] <= c5_q[i][COF_W-1] ? cmag_t'(-c5_q[i]) : cmag_t'(c5_q[i]);
      end
    end
  end

  assign valid_o = v_q[3];
  assign ad_o    = ad_q;
  assign cmag_o  = cmag_q;
  assign neg_o   = neg_q;

endmodule

`default_nettype wire

@@ hdl/mi3_div.sv @@
// ---------------------------------------------------------------------------
// mi3_div
// Nine restoring dividers sharing one divisor, one quotient bit per stage,
// with an overflow check up front that marks results to saturate.
// ---------------------------------------------------------------------------
`default_nettype none

module mi3_div import mi3_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                valid_i,
  input  wire logic                sing_i,
  input  wire logic [NUM_ELEM-1:0] neg_i,
  input  cmag_t                    num_i [NUM_ELEM],
  input  wire logic [DET_W-1:0]    den_i,
  output logic                     valid_o,
  output logic                     sing_o,
  output logic [NUM_ELEM-1:0]      neg_o,
  output logic [NUM_ELEM-1:0]      ovf_o,
  output logic [ELEM_W-2:0]        quo_o [NUM_ELEM]
);

  localparam int unsigned STEPS = ELEM_W - 1;
  localparam int unsigned NUM_W = COF_W + 2 * FRAC_BITS;
  localparam int unsigned SHD_W = DET_W + ELEM_W - 1;
  localparam int unsigned RW    = (NUM_W > SHD_W) ? NUM_W : SHD_W;

  typedef logic [RW-1:0]    rem_t;
  typedef logic [STEPS-1:0] quo_t;

  rem_t                rem_q  [STEPS][NUM_ELEM];
  logic [DET_W-1:0]    den_q  [STEPS];
  quo_t                quo_q  [STEPS+1][NUM_ELEM];
  logic [NUM_ELEM-1:0] ovf_q  [STEPS+1];
  logic [NUM_ELEM-1:0] neg_q  [STEPS+1];
  logic [STEPS:0]      sing_q;
  logic [STEPS:0]      vld_q;

  rem_t                num_sh [NUM_ELEM];
  rem_t                den_top;

  always_comb begin
    den_top = rem_t'(den_i) << (ELEM_W - 1);
    for (int l = 0; l < NUM_ELEM; l++) begin
      num_sh[l] = rem_t'(num_i[l]) << (2 * FRAC_BITS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[STEPS-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_t dsh;
    if (en_i) begin
      den_q[0]  <= den_i;
      sing_q[0] <= sing_i;
      neg_q[0]  <= neg_i;
      for (int l = 0; l < NUM_ELEM; l++) begin
        rem_q[0][l] <= num_sh[l];
        quo_q[0][l] <= '0;
        ovf_q[0][l] <= (num_sh[l] >= den_top);
      end
      for (int s = 1; s <= STEPS; s++) begin
        dsh       = rem_t'(den_q[s-1]) << (STEPS - s);
        sing_q[s] <= sing_q[s-1];
        neg_q[s]  <= neg_q[s-1];
        ovf_q[s]  <= ovf_q[s-1];
        if (s < STEPS) den_q[s] <= den_q[s-1];
        for (int l = 0; l < NUM_ELEM; l++) begin
          quo_q[s][l] <= quo_q[s-1][l];
          if (rem_q[s-1][l] >= dsh) begin
            quo_q[s][l][STEPS-s] <= 1'b1;
            if (s < STEPS) rem_q[s][l] <= rem_q[s-1][l] - dsh;
          end else begin
            if (s < STEPS) rem_q[s][l] <= rem_q[s-1][l];
          end
        end
      end
    end
  end

  assign valid_o = vld_q[STEPS];
  assign sing_o  = sing_q[STEPS];
  assign neg_o   = neg_q[STEPS];
  assign ovf_o   = ovf_q[STEPS];
  assign quo_o   = quo_q[STEPS];

endmodule

`default_nettype wire

@@ hdl/matrix3x3_inverse_unit.sv @@
// ---------------------------------------------------------------------------
// matrix3x3_inverse_unit
// Inverse of a signed fixed-point 3x3 matrix by adjugate over determinant,
// identity with a singular flag when |det| is within the threshold.
//
//   channel  direction  handshake            beat
//   in       input      in_valid_i/in_stall_o    in_beat_t (nine elements)
//   out      output     out_valid_o/out_stall_i  out_beat_t (nine + singular)
//   cfg      input      cfg_valid_i/cfg_ready_o  singular_threshold, 16 bits
//
// One beat per cycle in and out while the output is not stalled; the divider
// resolves one quotient bit per stage.
// Reset clears all valid bits and sets the threshold to 1.
// A stalled output beat freezes the whole pipeline; in_stall_o follows it.
// ---------------------------------------------------------------------------
`default_nettype none

module matrix3x3_inverse_unit import mi3_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  in_beat_t              in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output out_beat_t             out_data_o,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [THR_W-1:0] cfg_data_i
);

  `include "matrix3x3_inverse_unit_macros.svh"

  localparam logic [ELEM_W-1:0] MAXPOS  = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic [ELEM_W-1:0] MINNEG  = {1'b1, {(ELEM_W-1){1'b0}}};
  localparam logic [ELEM_W-1:0] ONE_VAL =
    (FRAC_BITS >= ELEM_W - 1) ? MAXPOS : (ELEM_W'(1) << FRAC_BITS);

  logic                en;
  logic [THR_W-1:0]    thr_q;

  logic                cof_valid;
  cof_t                cof [NUM_ELEM];
  elem_t               row0 [3];

  logic                det_valid;
  logic [DET_W-1:0]    ad;
  cmag_t               cmag [NUM_ELEM];
  logic [NUM_ELEM-1:0] det_neg;
  logic                sing;

  logic                div_valid;
  logic                div_sing;
  logic [NUM_ELEM-1:0] div_neg;
  logic [NUM_ELEM-1:0] div_ovf;
  logic [ELEM_W-2:0]   div_quo [NUM_ELEM];

  mat_t                res;
  out_beat_t           out_q;
  logic                out_valid_q;

  assign en          = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_W'(1);
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  mi3_cofactor u_cof (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .mat_i   (unpack_in(in_data_i)),
    .valid_o (cof_valid),
    .cof_o   (cof),
    .row0_o  (row0)
  );

  mi3_det u_det (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cof_valid),
    .cof_i   (cof),
    .row0_i  (row0),
    .valid_o (det_valid),
    .ad_o    (ad),
    .cmag_o  (cmag),
    .neg_o   (det_neg)
  );

  assign sing = (ad <= (DET_W'(thr_q) << (2 * FRAC_BITS)));

  mi3_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (det_valid),
    .sing_i  (sing),
    .neg_i   (det_neg),
    .num_i   (cmag),
    .den_i   (ad),
    .valid_o (div_valid),
    .sing_o  (div_sing),
    .neg_o   (div_neg),
    .ovf_o   (div_ovf),
    .quo_o   (div_quo)
  );

  always_comb begin
    for (int l = 0; l < NUM_ELEM; l++) begin
      if (div_sing) begin
        res[l] = ((l % 4) == 0) ? ONE_VAL : '0;
      end else if (div_ovf[l]) begin
        res[l] = div_neg[l] ? MINNEG : MAXPOS;
      end else if (div_neg[l]) begin
        res[l] = -$signed({1'b0, div_quo[l]});
      end else begin
        res[l] = $signed({1'b0, div_quo[l]});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= pack_out(res, div_sing);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `MI3_ASSERT_SAME(a_stall_back, out_valid_o && out_stall_i, in_stall_o,
    "input not stalled while output beat is held")
  `MI3_ASSERT_NEXT(a_div_to_out, div_valid && en, out_valid_o,
    "divider result did not reach the output register")
  `MI3_ASSERT_SAME(a_sing_ident, out_valid_o && out_data_o.singular,
    out_data_o.out_r0c0 == ONE_VAL && out_data_o.out_r0c1 == '0 && out_data_o.out_r1c0 == '0,
    "singular beat is not the identity")

endmodule

`default_nettype wire
